// File: hw/rtl/fsgs_pkg.sv
// Shared types, register map, cell codes and threshold helper for the fire-spread grid step.
package fsgs_pkg;

    localparam int MAX_SIZE_DEF = 32;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;
    localparam int DRAW_W       = 16;
    localparam int CHG_W        = 11;
    localparam int THR_W        = 4;
    localparam int PCT_W        = 7;
    localparam int GRID_W       = 6;
    localparam int NB_COUNT     = 8;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_GRID  = 2'd0;
    localparam logic [1:0] REG_NEIGH = 2'd1;
    localparam logic [1:0] REG_CATCH = 2'd2;

    localparam logic [GRID_W-1:0] RST_GRID  = 6'd32;
    localparam logic [PCT_W-1:0]  RST_NEIGH = 7'd50;
    localparam logic [PCT_W-1:0]  RST_CATCH = 7'd50;

    // cell codes
    localparam logic [1:0] ST_LIVE    = 2'd1;
    localparam logic [1:0] ST_BURNING = 2'd2;
    localparam logic [1:0] ST_BURNED  = 2'd3;

    // neighbor slots around the center cell
    localparam int NB_NW = 0;
    localparam int NB_N  = 1;
    localparam int NB_NE = 2;
    localparam int NB_W  = 3;
    localparam int NB_E  = 4;
    localparam int NB_SW = 5;
    localparam int NB_S  = 6;
    localparam int NB_SE = 7;

    typedef struct packed {
        logic [DRAW_W-1:0] draw;
        logic [1:0]        state;
    } item_t;

    typedef logic [NB_COUNT-1:0][1:0] nbr_t;

    typedef struct packed {
        logic [THR_W-1:0] thr3;
        logic [THR_W-1:0] thr5;
        logic [THR_W-1:0] thr8;
    } thr_t;

    typedef struct packed {
        logic emit;
        logic clear;
        logic frame_last;
        logic top_row;
        logic bottom_row;
        logic left_col;
        logic right_col;
    } pos_t;

    typedef struct packed {
        logic [1:0]       new_state;
        logic             cell_changed;
        logic             frame_end;
        logic [CHG_W-1:0] frame_changes;
        logic             fire_alive;
    } res_t;

    // floor(kp / 100) for kp up to 1016, by reciprocal multiply
    function automatic logic [THR_W-1:0] thr_of(input logic [9:0] kp);
        logic [22:0] prod;
        prod = 23'(kp) * 23'd5243;
        return prod[22:19];
    endfunction

    localparam logic [THR_W-1:0] RST_THR3 = thr_of(10'(3 * RST_NEIGH));
    localparam logic [THR_W-1:0] RST_THR5 = thr_of(10'(5 * RST_NEIGH));
    localparam logic [THR_W-1:0] RST_THR8 = thr_of(10'(8 * RST_NEIGH));

endpackage

// File: hw/rtl/fsgs_cell.sv
// One chain cell: holds a grid item, loads from its left neighbor or from the chain entry.
module fsgs_cell (
    input  logic            clk,
    input  logic            shift,
    input  logic            load_entry,
    input  fsgs_pkg::item_t from_prev,
    input  fsgs_pkg::item_t from_entry,
    output fsgs_pkg::item_t held
);
    import fsgs_pkg::*;

    item_t held_reg;
    item_t held_next;

    always_comb
    begin
        held_next = load_entry ? from_entry : from_prev;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            held_reg <= held_next;
        end
    end

    assign held = held_reg;

endmodule

// File: hw/rtl/fsgs_line.sv
// Row delay chain of cells with a selectable entry point, giving a delay of LEN - entry shifts.
module fsgs_line #(
    parameter int LEN = fsgs_pkg::MAX_SIZE_DEF - 1,
    parameter int EW  = $clog2(fsgs_pkg::MAX_SIZE_DEF)
) (
    input  logic            clk,
    input  logic            shift,
    input  logic [EW-1:0]   entry,
    input  fsgs_pkg::item_t din,
    output fsgs_pkg::item_t dout
);
    import fsgs_pkg::*;

    item_t held [LEN];

    for (genvar i = 0; i < LEN; i++)
    begin : g_cell
        localparam logic [EW-1:0] IDX = EW'(i);
        item_t prev;

        if (i == 0)
        begin : g_first
            assign prev = din;
        end
        else
        begin : g_rest
            assign prev = held[i-1];
        end

        fsgs_cell u_cell (
            .clk        (clk),
            .shift      (shift),
            .load_entry (entry == IDX),
            .from_prev  (prev),
            .from_entry (din),
            .held       (held[i])
        );
    end

    assign dout = held[LEN-1];

endmodule

// File: hw/rtl/fsgs_eval.sv
// Burn rule for the center cell of the window, plus running change count and ignition flag.
module fsgs_eval (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fsgs_pkg::item_t               center,
    input  fsgs_pkg::nbr_t                nbr,
    input  fsgs_pkg::pos_t                pos,
    input  fsgs_pkg::thr_t                thr,
    input  logic [fsgs_pkg::PCT_W-1:0]    catch_pct,
    output fsgs_pkg::res_t                res
);
    import fsgs_pkg::*;

    logic [CHG_W-1:0]    count_reg;
    logic                alive_reg;
    logic [NB_COUNT-1:0] nb_ok;
    logic [NB_COUNT-1:0] burn;
    logic [THR_W-1:0]    cnt;
    logic [THR_W-1:0]    thr_sel;
    logic                row_edge;
    logic                col_edge;
    logic [22:0]         draw_x100;
    logic [22:0]         catch_lim;
    logic                catch_ok;
    logic                ignite;
    logic                burnout;
    logic                changed;
    logic [1:0]          ns;

    always_comb
    begin
        nb_ok[NB_NW] = !pos.top_row && !pos.left_col;
        nb_ok[NB_N]  = !pos.top_row;
        nb_ok[NB_NE] = !pos.top_row && !pos.right_col;
        nb_ok[NB_W]  = !pos.left_col;
        nb_ok[NB_E]  = !pos.right_col;
        nb_ok[NB_SW] = !pos.bottom_row && !pos.left_col;
        nb_ok[NB_S]  = !pos.bottom_row;
        nb_ok[NB_SE] = !pos.bottom_row && !pos.right_col;

        cnt = '0;
        for (int i = 0; i < NB_COUNT; i++)
        begin
            burn[i] = nb_ok[i] && (nbr[i] == ST_BURNING);
            cnt     = cnt + THR_W'(burn[i]);
        end

        row_edge = pos.top_row || pos.bottom_row;
        col_edge = pos.left_col || pos.right_col;
        if (row_edge && col_edge)
        begin
            thr_sel = thr.thr3;
        end
        else if (row_edge || col_edge)
        begin
            thr_sel = thr.thr5;
        end
        else
        begin
            thr_sel = thr.thr8;
        end

        // draw * 100 against catch_pct * 65536
        draw_x100 = 23'({center.draw, 6'b0}) + 23'({center.draw, 5'b0})
                  + 23'({center.draw, 2'b0});
        catch_lim = {catch_pct, 16'b0};
        catch_ok  = draw_x100 <= catch_lim;

        ignite  = (center.state == ST_LIVE) && (thr_sel != '0) && (cnt >= thr_sel)
                && catch_ok;
        burnout = center.state == ST_BURNING;
        changed = ignite || burnout;

        if (ignite)
        begin
            ns = ST_BURNING;
        end
        else if (burnout)
        begin
            ns = ST_BURNED;
        end
        else
        begin
            ns = center.state;
        end

        res.new_state     = ns;
        res.cell_changed  = changed;
        res.frame_end     = pos.frame_last;
        res.frame_changes = count_reg + CHG_W'(changed);
        res.fire_alive    = alive_reg || ignite;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            alive_reg <= 1'b0;
        end
        else if (pos.clear || (pos.emit && pos.frame_last))
        begin
            count_reg <= '0;
            alive_reg <= 1'b0;
        end
        else if (pos.emit)
        begin
            count_reg <= res.frame_changes;
            alive_reg <= res.fire_alive;
        end
    end

`ifndef SYNTH
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pos.emit && !pos.clear |=> $stable(count_reg) && $stable(alive_reg))
        else $error("change count moved without an emitted cell");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pos.emit && pos.frame_last |=> count_reg == '0 && !alive_reg)
        else $error("generation totals not cleared after last cell");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        pos.emit && changed && !pos.frame_last && !pos.clear
        |=> count_reg == $past(count_reg) + CHG_W'(1))
        else $error("change count did not advance on a changed cell");
`endif

endmodule

// File: hw/rtl/fire_spread_grid_step.sv
// Top level of the fire-spread grid step: config port, window chain, sequencing and output skid.
// Throughput: one cell per cycle; after the last cell of a grid the input stalls while the
// window chain drains the last row plus one cell, and it also stalls while the skid holds a result.
// Output: cell q is registered at the shift that takes cell q+n+1 (one row plus one cell) or a flush shift.
// Reset: config returns to 32/50/50, frame position and totals clear; the chain cells are not
// reset and need no clearing pass, since only cells of the current grid are ever read.
module fire_spread_grid_step #(
    parameter int MAX_SIZE = fsgs_pkg::MAX_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fsgs_pkg::ADDR_W-1:0]     paddr,
    input  logic [fsgs_pkg::DATA_W-1:0]     pwdata,
    output logic [fsgs_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      cell_state,
    input  logic [fsgs_pkg::DRAW_W-1:0]     catch_draw,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      new_state,
    output logic                            cell_changed,
    output logic                            frame_end,
    output logic [fsgs_pkg::CHG_W-1:0]      frame_changes,
    output logic                            fire_alive
);
    import fsgs_pkg::*;

    localparam int NW  = $clog2(MAX_SIZE + 1);
    localparam int CW  = $clog2(MAX_SIZE);
    localparam int EW  = $clog2(MAX_SIZE);
    localparam int LEN = MAX_SIZE - 1;
    localparam int VW  = $clog2(MAX_SIZE * MAX_SIZE + MAX_SIZE + 1);
    localparam int N_RST  = (int'(RST_GRID) > MAX_SIZE) ? MAX_SIZE : int'(RST_GRID);
    localparam int N2_RST = (N_RST < 2) ? 2 : N_RST;

    // config
    logic [GRID_W-1:0] grid_reg;
    logic [PCT_W-1:0]  neigh_reg;
    logic [PCT_W-1:0]  catch_reg;
    logic [NW-1:0]     n_reg;
    logic [CW-1:0]     nm1_reg;
    logic [VW-1:0]     total_m1_reg;
    logic [EW-1:0]     entry_reg;
    thr_t              thr_reg;

    logic              cfg_wr;
    logic              grid_wr;
    logic [GRID_W-1:0] g_w;
    logic [PCT_W-1:0]  p_w;
    logic [NW-1:0]     n_w;
    logic [NW-1:0]     n2_w;
    logic [9:0]        kp3;
    logic [9:0]        kp5;
    logic [9:0]        kp8;

    // sequencing
    logic [VW-1:0] v_reg;
    logic [VW-1:0] v_next;
    logic          emit_on_reg;
    logic          emit_on_next;
    logic          flush_reg;
    logic          flush_next;
    logic [CW-1:0] rq_reg;
    logic [CW-1:0] rq_next;
    logic [CW-1:0] cq_reg;
    logic [CW-1:0] cq_next;
    logic          in_accept;
    logic          shift;
    logic          emit;
    logic          frame_last;
    logic          frame_done;
    logic          last_in;

    // window chain
    item_t din;
    item_t w01;
    item_t w02;
    item_t w10;
    item_t w11;
    item_t w12;
    item_t w20;
    item_t w21;
    item_t w22;
    item_t center;
    nbr_t  nbr;
    pos_t  pos;
    res_t  res;

    // output register and skid
    res_t out_reg;
    res_t out_next;
    res_t skid_reg;
    res_t skid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic out_take;

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign grid_wr = cfg_wr && (paddr[3:2] == REG_GRID);

    always_comb
    begin
        g_w = pwdata[GRID_W-1:0];
        p_w = pwdata[PCT_W-1:0];
        if (g_w == '0)
        begin
            n_w = NW'(1);
        end
        else if (g_w > GRID_W'(MAX_SIZE))
        begin
            n_w = NW'(MAX_SIZE);
        end
        else
        begin
            n_w = NW'(g_w);
        end
        n2_w = (n_w < NW'(2)) ? NW'(2) : n_w;
        kp3  = 10'({p_w, 1'b0}) + 10'(p_w);
        kp5  = 10'({p_w, 2'b0}) + 10'(p_w);
        kp8  = 10'({p_w, 3'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg     <= RST_GRID;
            neigh_reg    <= RST_NEIGH;
            catch_reg    <= RST_CATCH;
            n_reg        <= NW'(N_RST);
            nm1_reg      <= CW'(N_RST - 1);
            total_m1_reg <= VW'(N_RST * N_RST - 1);
            entry_reg    <= EW'(MAX_SIZE - N2_RST);
            thr_reg      <= '{thr3: RST_THR3, thr5: RST_THR5, thr8: RST_THR8};
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_GRID:
                begin
                    grid_reg     <= g_w;
                    n_reg        <= n_w;
                    nm1_reg      <= CW'(n_w - NW'(1));
                    total_m1_reg <= VW'(VW'(n_w) * VW'(n_w) - VW'(1));
                    entry_reg    <= EW'(NW'(MAX_SIZE) - n2_w);
                end
                REG_NEIGH:
                begin
                    neigh_reg <= p_w;
                    thr_reg   <= '{thr3: thr_of(kp3), thr5: thr_of(kp5), thr8: thr_of(kp8)};
                end
                REG_CATCH:
                begin
                    catch_reg <= p_w;
                end
                default:
                begin
                    catch_reg <= catch_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_GRID:  prdata = DATA_W'(grid_reg);
            REG_NEIGH: prdata = DATA_W'(neigh_reg);
            REG_CATCH: prdata = DATA_W'(catch_reg);
            default:   prdata = '0;
        endcase
    end

    // ---------------- sequencing ----------------
    assign in_stall   = flush_reg || skid_valid_reg;
    assign in_accept  = in_valid && !in_stall;
    assign shift      = !skid_valid_reg && (flush_reg || in_valid);
    assign emit       = shift && emit_on_reg;
    assign frame_last = (rq_reg == nm1_reg) && (cq_reg == nm1_reg);
    assign frame_done = emit && frame_last;
    assign last_in    = in_accept && (v_reg == total_m1_reg);

    always_comb
    begin
        v_next       = v_reg;
        emit_on_next = emit_on_reg;
        flush_next   = flush_reg;
        rq_next      = rq_reg;
        cq_next      = cq_reg;
        if (grid_wr || (shift && frame_done))
        begin
            v_next       = '0;
            emit_on_next = 1'b0;
            flush_next   = 1'b0;
            rq_next      = '0;
            cq_next      = '0;
        end
        else if (shift)
        begin
            v_next = v_reg + VW'(1);
            // the cell one row plus one behind is complete from here on
            if (v_reg == VW'(n_reg))
            begin
                emit_on_next = 1'b1;
            end
            if (last_in)
            begin
                flush_next = 1'b1;
            end
            if (emit)
            begin
                if (cq_reg == nm1_reg)
                begin
                    cq_next = '0;
                    rq_next = rq_reg + CW'(1);
                end
                else
                begin
                    cq_next = cq_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg       <= '0;
            emit_on_reg <= 1'b0;
            flush_reg   <= 1'b0;
            rq_reg      <= '0;
            cq_reg      <= '0;
        end
        else
        begin
            v_reg       <= v_next;
            emit_on_reg <= emit_on_next;
            flush_reg   <= flush_next;
            rq_reg      <= rq_next;
            cq_reg      <= cq_next;
        end
    end

    // ---------------- window chain ----------------
    assign din = '{draw: catch_draw, state: cell_state};

    fsgs_cell u_w01 (
        .clk(clk), .shift(shift), .load_entry(1'b0),
        .from_prev(din), .from_entry(din), .held(w01)
    );
    fsgs_cell u_w02 (
        .clk(clk), .shift(shift), .load_entry(1'b0),
        .from_prev(w01), .from_entry(w01), .held(w02)
    );

    fsgs_line #(.LEN(LEN), .EW(EW)) u_line1 (
        .clk(clk), .shift(shift), .entry(entry_reg), .din(w01), .dout(w10)
    );

    fsgs_cell u_w11 (
        .clk(clk), .shift(shift), .load_entry(1'b0),
        .from_prev(w10), .from_entry(w10), .held(w11)
    );
    fsgs_cell u_w12 (
        .clk(clk), .shift(shift), .load_entry(1'b0),
        .from_prev(w11), .from_entry(w11), .held(w12)
    );

    fsgs_line #(.LEN(LEN), .EW(EW)) u_line2 (
        .clk(clk), .shift(shift), .entry(entry_reg), .din(w11), .dout(w20)
    );

    fsgs_cell u_w21 (
        .clk(clk), .shift(shift), .load_entry(1'b0),
        .from_prev(w20), .from_entry(w20), .held(w21)
    );
    fsgs_cell u_w22 (
        .clk(clk), .shift(shift), .load_entry(1'b0),
        .from_prev(w21), .from_entry(w21), .held(w22)
    );

    always_comb
    begin
        // a one-cell grid has no row delay: its center is two shifts back
        center      = (n_reg == NW'(1)) ? w02 : w11;
        nbr[NB_NW]  = w22.state;
        nbr[NB_N]   = w21.state;
        nbr[NB_NE]  = w20.state;
        nbr[NB_W]   = w12.state;
        nbr[NB_E]   = w10.state;
        nbr[NB_SW]  = w02.state;
        nbr[NB_S]   = w01.state;
        nbr[NB_SE]  = din.state;

        pos.emit       = emit;
        pos.clear      = grid_wr;
        pos.frame_last = frame_last;
        pos.top_row    = rq_reg == '0;
        pos.bottom_row = rq_reg == nm1_reg;
        pos.left_col   = cq_reg == '0;
        pos.right_col  = cq_reg == nm1_reg;
    end

    fsgs_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .center    (center),
        .nbr       (nbr),
        .pos       (pos),
        .thr       (thr_reg),
        .catch_pct (catch_reg),
        .res       (res)
    );

    // ---------------- output register and skid ----------------
    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_next       = res;
            out_valid_next = emit;
        end
        else if (emit)
        begin
            // hold the new item while the output is stalled
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = out_valid_reg;
    assign new_state     = out_reg.new_state;
    assign cell_changed  = out_reg.cell_changed;
    assign frame_end     = out_reg.frame_end;
    assign frame_changes = out_reg.frame_changes;
    assign fire_alive    = out_reg.fire_alive;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output is empty");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> v_reg == '0 && !flush_reg && !emit_on_reg)
        else $error("frame position not restarted after last cell");

    a_emit_window: assert property (@(posedge clk) disable iff (!rst_n)
        emit_on_reg |-> VW'(n_reg) < v_reg)
        else $error("emission enabled before the window is filled");
`endif

endmodule

// File: test/fire_spread_grid_step_test.sv
// Self-checking testbench for the fire-spread grid step: directed table, random frames, APB setup.
module fire_spread_grid_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fsgs_pkg::*;

    localparam int         CELLS        = MAX_SIZE_DEF * MAX_SIZE_DEF;
    localparam int         DRAIN_WAIT   = MAX_SIZE_DEF + 4;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         RANDOM_ITEMS = 270;
    localparam int         REPORT_MAX   = 10;
    localparam int         SCRIPT_LEN   = 33;
    localparam logic [1:0] ST_EMPTY     = 2'd0;
    localparam logic [1:0] REG_SPARE    = 2'd3;

    typedef enum logic {ROW_CFG, ROW_CELL} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [31:0] a;      // register index or cell state
        logic [31:0] b;      // register value or catch draw
        bit          typed;  // want holds the known result of a one-cell grid
        res_t        want;
    } stim_row_t;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [ADDR_W-1:0]   paddr      = '0;
    logic [DATA_W-1:0]   pwdata     = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [1:0]          cell_state = '0;
    logic [DRAW_W-1:0]   catch_draw = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [1:0]          new_state;
    logic                cell_changed;
    logic                frame_end;
    logic [CHG_W-1:0]    frame_changes;
    logic                fire_alive;

    // shadow of the grid and the block's registers
    item_t               board [CELLS];
    logic [GRID_W-1:0]   grid_cfg     = RST_GRID;
    logic [PCT_W-1:0]    neigh_cfg    = RST_NEIGH;
    logic [PCT_W-1:0]    catch_cfg    = RST_CATCH;
    int unsigned         cell_pos     = 0;
    logic [CHG_W-1:0]    change_total = '0;
    logic                ignited      = 1'b0;
    res_t                pending_cells [$];

    int                  errors     = 0;
    int                  idle_run   = 0;
    int                  burst_left = 0;
    int                  items_sent = 0;
    int                  stall_mode = 0;
    int                  stall_run  = 0;

    stim_row_t script [SCRIPT_LEN] = '{
        '{ROW_CFG,  32'(REG_GRID),   32'd0,        1'b0, '0},
        '{ROW_CELL, 32'(ST_EMPTY),   32'h0000,     1'b1, '{ST_EMPTY,   1'b0, 1'b1, 11'd0, 1'b0}},
        '{ROW_CELL, 32'(ST_LIVE),    32'h0000,     1'b1, '{ST_LIVE,    1'b0, 1'b1, 11'd0, 1'b0}},
        '{ROW_CELL, 32'(ST_BURNING), 32'hFFFF,     1'b1, '{ST_BURNED,  1'b1, 1'b1, 11'd1, 1'b0}},
        '{ROW_CELL, 32'(ST_BURNED),  32'h0000,     1'b1, '{ST_BURNED,  1'b0, 1'b1, 11'd0, 1'b0}},
        '{ROW_CFG,  32'(REG_SPARE),  32'd7,        1'b0, '0},
        '{ROW_CFG,  32'(REG_NEIGH),  32'hFFFF_FFA2, 1'b0, '0},
        '{ROW_CFG,  32'(REG_CATCH),  32'd0,        1'b0, '0},
        '{ROW_CFG,  32'(REG_GRID),   32'd2,        1'b0, '0},
        '{ROW_CELL, 32'(ST_BURNING), 32'h1234,     1'b0, '0},
        '{ROW_CELL, 32'(ST_LIVE),    32'h0000,     1'b0, '0},
        '{ROW_CELL, 32'(ST_LIVE),    32'h0001,     1'b0, '0},
        '{ROW_CELL, 32'(ST_LIVE),    32'hFFFF,     1'b0, '0},
        '{ROW_CFG,  32'(REG_NEIGH),  32'd127,      1'b0, '0},
        '{ROW_CFG,  32'(REG_CATCH),  32'd127,      1'b0, '0},
        '{ROW_CFG,  32'(REG_GRID),   32'd3,        1'b0, '0},
        '{ROW_CELL, 32'(ST_LIVE),    32'hFFFF,     1'b0, '0},
        '{ROW_CELL, 32'(ST_BURNING), 32'h0000,     1'b0, '0},
        '{ROW_CELL, 32'(ST_BURNING), 32'h8000,     1'b0, '0},
        '{ROW_CELL, 32'(ST_BURNING), 32'h7FFF,     1'b0, '0},
        '{ROW_CELL, 32'(ST_BURNING), 32'h0001,     1'b0, '0},
        '{ROW_CELL, 32'(ST_LIVE),    32'hFFFF,     1'b0, '0},
        '{ROW_CELL, 32'(ST_LIVE),    32'h5555,     1'b0, '0},
        '{ROW_CELL, 32'(ST_BURNING), 32'hAAAA,     1'b0, '0},
        '{ROW_CELL, 32'(ST_LIVE),    32'h0000,     1'b0, '0},
        '{ROW_CFG,  32'(REG_GRID),   32'd33,       1'b0, '0},
        '{ROW_CELL, 32'(ST_BURNING), 32'hFFFF,     1'b0, '0},
        '{ROW_CELL, 32'(ST_LIVE),    32'h0000,     1'b0, '0},
        '{ROW_CELL, 32'(ST_LIVE),    32'h00FF,     1'b0, '0},
        '{ROW_CFG,  32'(REG_GRID),   32'd63,       1'b0, '0},
        '{ROW_CELL, 32'(ST_LIVE),    32'hFF00,     1'b0, '0},
        '{ROW_CELL, 32'(ST_BURNING), 32'h0000,     1'b0, '0},
        '{ROW_CELL, 32'(ST_LIVE),    32'h0F0F,     1'b0, '0}
    };

    fire_spread_grid_step dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic note_mismatch(input string msg);
        errors++;
        if (errors <= REPORT_MAX)
            $display("%s", msg);
    endtask

    // next state of stored cell q, counted into the running frame totals
    function automatic res_t next_state_at(input int unsigned n, input int unsigned q,
                                           input bit last);
        int unsigned r, c, k, thr, burning;
        int          rr, cc, dy, dx;
        res_t        res;
        r = q / n;
        c = q % n;
        res = '0;
        res.new_state = board[q].state;
        if (board[q].state == ST_LIVE)
        begin
            burning = 0;
            for (dy = -1; dy <= 1; dy++)
            begin
                for (dx = -1; dx <= 1; dx++)
                begin
                    rr = int'(r) + dy;
                    cc = int'(c) + dx;
                    if ((dy != 0 || dx != 0) && rr >= 0 && cc >= 0 && rr < int'(n)
                        && cc < int'(n) && board[rr * n + cc].state == ST_BURNING)
                        burning++;
                end
            end
            k = ((r == 0 || r == n - 1) && (c == 0 || c == n - 1)) ? 3 :
                ((r == 0 || r == n - 1 || c == 0 || c == n - 1) ? 5 : 8);
            thr = k * neigh_cfg / 100;
            if (thr != 0 && burning >= thr
                && 32'(board[q].draw) * 100 <= 32'(catch_cfg) * 65536)
            begin
                res.new_state = ST_BURNING;
                res.cell_changed = 1'b1;
                ignited = 1'b1;
            end
        end
        else if (board[q].state == ST_BURNING)
        begin
            res.new_state = ST_BURNED;
            res.cell_changed = 1'b1;
        end
        change_total += CHG_W'(res.cell_changed);
        res.frame_end = last;
        res.frame_changes = change_total;
        res.fire_alive = ignited;
        return res;
    endfunction

    // store an accepted item and queue every cell whose neighborhood is now complete
    function automatic void take_cell(input logic [1:0] st, input logic [DRAW_W-1:0] dr,
                                      input bit typed, input res_t want);
        int unsigned n, total, p, lo, hi, q;
        bit          last;
        res_t        res;
        n = (grid_cfg == 0) ? 1 : ((grid_cfg > MAX_SIZE_DEF) ? MAX_SIZE_DEF : grid_cfg);
        total = n * n;
        p = (cell_pos >= total) ? 0 : cell_pos;
        board[p].state = st;
        board[p].draw = dr;
        last = (p == total - 1);
        if (p >= n + 1 || last)
        begin
            lo = (p >= n + 1) ? p - n - 1 : 0;
            hi = last ? p : p - n - 1;
            for (q = lo; q <= hi; q++)
            begin
                res = next_state_at(n, q, last && q == hi);
                pending_cells.push_back(typed ? want : res);
            end
        end
        if (last)
        begin
            cell_pos = 0;
            change_total = '0;
            ignited = 1'b0;
        end
        else
            cell_pos = p + 1;
    endfunction

    task automatic check_reg(input logic [1:0] idx, input logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_W'({idx, 2'b00});
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            note_mismatch($sformatf("register %0d read %h, expected %h", idx, got, want));
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GRID:
            begin
                // a size write restarts the frame
                grid_cfg = value[GRID_W-1:0];
                cell_pos = 0;
                change_total = '0;
                ignited = 1'b0;
                check_reg(idx, DATA_W'(value[GRID_W-1:0]));
            end
            REG_NEIGH:
            begin
                neigh_cfg = value[PCT_W-1:0];
                check_reg(idx, DATA_W'(value[PCT_W-1:0]));
            end
            REG_CATCH:
            begin
                catch_cfg = value[PCT_W-1:0];
                check_reg(idx, DATA_W'(value[PCT_W-1:0]));
            end
            default:
            begin
            end
        endcase
    endtask

    // drop valid and hold until every queued result is out; full adds the flush latency
    task automatic settle(input bit full);
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        if (full)
            repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic push_cell(input logic [1:0] st, input logic [DRAW_W-1:0] dr,
                             input bit typed, input res_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cell_state <= st;
        catch_draw <= dr;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        take_cell(st, dr, typed, want);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic [PCT_W-1:0] pick_pct();
        case ($urandom_range(0, 5))
            0:       return PCT_W'(0);
            1:       return PCT_W'(100);
            2:       return PCT_W'(127);
            default: return PCT_W'($urandom_range(1, 99));
        endcase
    endfunction

    initial
    begin
        int unsigned       size, n, count, phase;
        logic [1:0]        st;
        logic [DRAW_W-1:0] dr;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        check_reg(REG_GRID, DATA_W'(RST_GRID));
        check_reg(REG_NEIGH, DATA_W'(RST_NEIGH));
        check_reg(REG_CATCH, DATA_W'(RST_CATCH));

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                settle(1'b1);
                reg_write(script[i].a[1:0], script[i].b);
            end
            else
                push_cell(script[i].a[1:0], script[i].b[DRAW_W-1:0], script[i].typed,
                          script[i].want);
        end

        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            settle(1'b1);
            if (phase == 0 || $urandom_range(0, 7) == 0)
            begin
                // large grid: a partial frame only, cut short by the next size write
                case ($urandom_range(0, 2))
                    0:       size = MAX_SIZE_DEF;
                    1:       size = $urandom_range(MAX_SIZE_DEF + 1, 62);
                    default: size = 63;
                endcase
                count = $urandom_range(40, 80);
            end
            else
            begin
                size = $urandom_range(0, 7);
                n = (size == 0) ? 1 : size;
                count = n * n * $urandom_range(1, 3);
                if (n > 1 && $urandom_range(0, 3) == 0)
                    count += $urandom_range(1, n * n - 1);
            end
            if (count > RANDOM_ITEMS - items_sent)
                count = RANDOM_ITEMS - items_sent;
            reg_write(REG_NEIGH, ($urandom() & ~32'h7F) | DATA_W'(pick_pct()));
            reg_write(REG_CATCH, ($urandom() & ~32'h7F) | DATA_W'(pick_pct()));
            reg_write(REG_GRID, ($urandom() & ~32'h3F) | size);
            repeat (count)
            begin
                case ($urandom_range(0, 9))
                    0, 1:       st = ST_EMPTY;
                    2, 3, 4, 5: st = ST_LIVE;
                    6, 7, 8:    st = ST_BURNING;
                    default:    st = ST_BURNED;
                endcase
                if ($urandom_range(0, 7) == 0)
                    dr = ($urandom_range(0, 1) == 1) ? '1 : '0;
                else
                    dr = DRAW_W'($urandom_range(0, 65535));
                push_cell(st, dr, 1'b0, '0);
                if ($urandom_range(0, 59) == 0)
                    settle(1'b0);
            end
            phase++;
        end

        settle(1'b1);
        if (errors == 0 && pending_cells.size() == 0)
            $display("[fire_spread_grid_step] OK");
        else
            $display("[fire_spread_grid_step] ERROR");
        $finish;
    end

    // receiver stall pattern: free runs, light, heavy and sparse stalls
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_run <= $urandom_range(4, 60);
        end
        else
            stall_run <= stall_run - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            2:       out_stall <= ($urandom_range(0, 5) != 0);
            default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            got.new_state = new_state;
            got.cell_changed = cell_changed;
            got.frame_end = frame_end;
            got.frame_changes = frame_changes;
            got.fire_alive = fire_alive;
            if (pending_cells.size() == 0)
                note_mismatch("cell result arrived with none expected");
            else
            begin
                want = pending_cells.pop_front();
                if (got.new_state !== want.new_state || got.cell_changed !== want.cell_changed
                    || got.frame_end !== want.frame_end
                    || got.frame_changes !== want.frame_changes
                    || got.fire_alive !== want.fire_alive)
                    note_mismatch($sformatf({"cell mismatch: expected state %0d chg %0d ",
                        "end %0d count %0d alive %0d, got state %0d chg %0d end %0d ",
                        "count %0d alive %0d"},
                        want.new_state, want.cell_changed, want.frame_end,
                        want.frame_changes, want.fire_alive, got.new_state,
                        got.cell_changed, got.frame_end, got.frame_changes,
                        got.fire_alive));
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run > IDLE_LIMIT)
        begin
            $display("[fire_spread_grid_step] ERROR");
            $finish;
        end
    end

endmodule
